### sv/dbcs_pkg.sv
// Shared constants, types and helper functions for the domain binning sorter.
`timescale 1ns / 1ps
`default_nettype none

package dbcs_pkg;

  localparam int FRAC_W      = 24;
  localparam int DOM_W       = 5;
  localparam int DOM_MAX     = 16;
  localparam int G_W         = 4;
  localparam int CMD_W       = 3;
  localparam int SEL_W       = 12;
  localparam int ID_W        = 12;
  localparam int SLOT_W      = 20;
  localparam int CNT_W       = 21;
  localparam int STAT_W      = 2;
  localparam int MAX_DOMAINS = 4096;
  localparam int MAX_ATOMS   = 1048576;
  localparam int ADDR_W      = $clog2(MAX_DOMAINS);
  localparam int DXY_W       = 2 * DOM_W;
  localparam int DXYZ_W      = 3 * DOM_W;
  localparam int IDC_W       = G_W + DXY_W + 1;
  localparam int PROD_W      = FRAC_W + DOM_W;
  localparam int DIV_CNT_W   = $clog2(SEL_W);
  localparam int SLOT_MAX    = (1 << SLOT_W) - 1;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int RIDX_W      = PADDR_W - 2;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_COUNT = 3'd1,
    OP_BUILD = 3'd2,
    OP_PLACE = 3'd3,
    OP_READ  = 3'd4
  } dbcs_op_t;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFILL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  localparam logic [RIDX_W-1:0] REG_DX = 2'd0;
  localparam logic [RIDX_W-1:0] REG_DY = 2'd1;
  localparam logic [RIDX_W-1:0] REG_DZ = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DEC,
    S_BIN,
    S_IDX,
    S_RD,
    S_DX,
    S_DXW,
    S_DY,
    S_DYW,
    S_CLR,
    S_BLD,
    S_BTAIL,
    S_FIN
  } dbcs_state_t;

  typedef struct packed {
    logic load;
    logic bin;
    logic index;
    logic rd;
    logic div_x;
    logic div_y;
    logic clr_step;
    logic bld_step;
    logic finish;
  } dbcs_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             sel_ok;
    logic             sweep_last;
    logic             div_done;
    logic             out_free;
  } dbcs_stat_t;

  function automatic logic [DOM_W-1:0] eff_dom(input logic [DOM_W-1:0] r);
    if (r == '0) begin
      return DOM_W'(1);
    end else if (r > DOM_W'(DOM_MAX)) begin
      return DOM_W'(DOM_MAX);
    end else begin
      return r;
    end
  endfunction

  function automatic logic [SLOT_W-1:0] sat_slot(input logic [CNT_W:0] v);
    if (v > (CNT_W+1)'(SLOT_MAX)) begin
      return '1;
    end else begin
      return v[SLOT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### sv/dbcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/dbcs_div.sv
// Restoring divider, one quotient bit per cycle, for grid coordinate decode.
`timescale 1ns / 1ps
`default_nettype none

module dbcs_div import dbcs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SEL_W-1:0] dividend,
  input  wire logic [DOM_W-1:0] divisor,
  output      logic             done,
  output      logic [SEL_W-1:0] quo,
  output      logic [DOM_W-1:0] rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SEL_W-1:0]     quo_r;
  logic [SEL_W-1:0]     quo_nxt;
  logic [DOM_W-1:0]     rem_r;
  logic [DOM_W-1:0]     rem_nxt;
  logic [DOM_W-1:0]     div_r;
  logic [DOM_W:0]       rem_sh;
  logic [DOM_W:0]       diff;
  logic                 geq;

  always_comb begin
    rem_sh  = {rem_r, quo_r[SEL_W-1]};
    geq     = rem_sh >= {1'b0, div_r};
    diff    = rem_sh - {1'b0, div_r};
    rem_nxt = geq ? diff[DOM_W-1:0] : rem_sh[DOM_W-1:0];
    quo_nxt = {quo_r[SEL_W-2:0], geq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(SEL_W - 1);
      quo_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### sv/dbcs_ctrl.sv
// Sequencer for the domain binning sorter: one item at a time, sweeps over all domains.
`timescale 1ns / 1ps
`default_nettype none

module dbcs_ctrl import dbcs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire dbcs_stat_t stat,
  output      dbcs_cmd_t  cmd
);

  dbcs_state_t state_r;
  dbcs_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.cmd)
          OP_CLEAR: state_nxt = S_CLR;
          OP_COUNT: state_nxt = S_BIN;
          OP_PLACE: state_nxt = S_BIN;
          OP_BUILD: state_nxt = S_BLD;
          OP_READ:  state_nxt = stat.sel_ok ? S_DX : S_FIN;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_BIN: begin
        cmd.bin   = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.index = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIN;
      end
      S_DX: begin
        cmd.div_x = 1'b1;
        state_nxt = S_DXW;
      end
      S_DXW: begin
        if (stat.div_done) begin
          state_nxt = S_DY;
        end
      end
      S_DY: begin
        cmd.div_y = 1'b1;
        state_nxt = S_DYW;
      end
      S_DYW: begin
        if (stat.div_done) begin
          state_nxt = S_RD;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_FIN;
        end
      end
      S_BLD: begin
        cmd.bld_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_BTAIL;
        end
      end
      S_BTAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

### sv/dbcs_dp.sv
// Datapath: binning arithmetic, count/fill/offset memories, divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module dbcs_dp import dbcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dbcs_cmd_t         cmd,
  output      dbcs_stat_t        stat,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [FRAC_W-1:0] in_frac_x,
  input  wire logic [FRAC_W-1:0] in_frac_y,
  input  wire logic [FRAC_W-1:0] in_frac_z,
  input  wire logic [SEL_W-1:0]  in_domain_select,
  input  wire logic [DOM_W-1:0]  dom_x,
  input  wire logic [DOM_W-1:0]  dom_y,
  input  wire logic [DOM_W-1:0]  dom_z,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [ID_W-1:0]   out_domain_id,
  output      logic [SLOT_W-1:0] out_slot,
  output      logic [CNT_W-1:0]  out_count,
  output      logic [STAT_W-1:0] out_status,
  output      logic [G_W-1:0]    out_grid_x,
  output      logic [G_W-1:0]    out_grid_y,
  output      logic [G_W-1:0]    out_grid_z
);

  logic [CMD_W-1:0]  cmd_r;
  logic [FRAC_W-1:0] fx_r, fy_r, fz_r;
  logic [SEL_W-1:0]  sel_r;
  logic [DOM_W-1:0]  dx, dy, dz;
  logic [DXY_W-1:0]  dxy_r;
  logic [DXYZ_W-1:0] dxyz_r;
  logic [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic [G_W-1:0]    gx_r, gy_r, gz_r;
  logic              coord_ok_r;
  logic [IDC_W-1:0]  id_full;
  logic [ADDR_W-1:0] id_r;
  logic              id_ok_r;
  logic              sel_ok;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic              sweep_last;
  logic              bv_r;
  logic [ADDR_W-1:0] baddr_r;
  logic [CNT_W-1:0]  run_r;
  logic [CNT_W-1:0]  total_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              full, count_ok, place_ok, fill_upd;
  logic [CNT_W:0]    slot_sum;

  logic              cnt_we, cnt_re;
  logic [ADDR_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rd;
  logic              fill_we;
  logic [ADDR_W-1:0] fill_waddr;
  logic [CNT_W-1:0]  fill_wdata, fill_rd;
  logic [SLOT_W-1:0] off_wdata, off_rd;

  logic              div_start, div_done;
  logic [SEL_W-1:0]  div_dividend, div_quo;
  logic [DOM_W-1:0]  div_divisor, div_rem;

  logic [ID_W-1:0]   res_id;
  logic [SLOT_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_count;
  logic [STAT_W-1:0] res_status;
  logic [G_W-1:0]    res_gx, res_gy, res_gz;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [STAT_W-1:0] out_status_r;
  logic [G_W-1:0]    out_gx_r, out_gy_r, out_gz_r;

  assign dx = eff_dom(dom_x);
  assign dy = eff_dom(dom_y);
  assign dz = eff_dom(dom_z);

  // grid extents are registered: dxy_r from the config registers, dxyz_r from dxy_r
  always_ff @(posedge clk) begin
    dxy_r  <= DXY_W'(dx) * DXY_W'(dy);
    dxyz_r <= DXYZ_W'(dxy_r) * DXYZ_W'(dz);
  end

  assign prod_x  = PROD_W'(fx_r) * PROD_W'(dx);
  assign prod_y  = PROD_W'(fy_r) * PROD_W'(dy);
  assign prod_z  = PROD_W'(fz_r) * PROD_W'(dz);
  assign id_full = IDC_W'(gx_r) + IDC_W'(gy_r) * IDC_W'(dx) + IDC_W'(gz_r) * IDC_W'(dxy_r);
  assign sel_ok  = (DXYZ_W'(sel_r) < dxyz_r) && ({1'b0, sel_r} < (SEL_W+1)'(MAX_DOMAINS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      fx_r  <= in_frac_x;
      fy_r  <= in_frac_y;
      fz_r  <= in_frac_z;
      sel_r <= in_domain_select;
    end
    if (cmd.bin) begin
      gx_r       <= prod_x[FRAC_W +: G_W];
      gy_r       <= prod_y[FRAC_W +: G_W];
      gz_r       <= prod_z[FRAC_W +: G_W];
      coord_ok_r <= (fx_r != '0) && (fy_r != '0) && (fz_r != '0);
    end else if (cmd.div_y) begin
      gx_r <= div_rem[G_W-1:0];
    end
    if (cmd.index) begin
      id_r    <= id_full[ADDR_W-1:0];
      id_ok_r <= coord_ok_r && (id_full < IDC_W'(MAX_DOMAINS));
    end
    baddr_r <= sweep_r;
    if (cmd.load) begin
      run_r <= '0;
    end else if (bv_r) begin
      run_r <= run_r + cnt_rd;
    end
  end

  assign sweep_last = (sweep_r == ADDR_W'(MAX_DOMAINS - 1));
  assign sweep_nxt  = sweep_last ? '0 : sweep_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      bv_r    <= 1'b0;
      total_r <= '0;
    end else begin
      bv_r <= cmd.bld_step;
      if (cmd.clr_step || cmd.bld_step) begin
        sweep_r <= sweep_nxt;
      end
      if (cmd.finish && (cmd_r == OP_CLEAR)) begin
        total_r <= '0;
      end else if (cmd.finish && (cmd_r == OP_COUNT) && count_ok) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  assign rd_addr  = (cmd_r == OP_READ) ? sel_r[ADDR_W-1:0] : id_r;
  assign full     = total_r >= CNT_W'(MAX_ATOMS);
  assign count_ok = id_ok_r && !full;
  assign place_ok = id_ok_r && (fill_rd < cnt_rd);
  assign fill_upd = cmd.finish && (cmd_r == OP_PLACE) && place_ok;
  assign slot_sum = (CNT_W+1)'(off_rd) + (CNT_W+1)'(fill_rd);

  assign cnt_we     = cmd.clr_step || (cmd.finish && (cmd_r == OP_COUNT) && count_ok);
  assign cnt_waddr  = cmd.clr_step ? sweep_r : id_r;
  assign cnt_wdata  = cmd.clr_step ? '0 : cnt_rd + 1'b1;
  assign cnt_re     = cmd.rd || cmd.bld_step;
  assign cnt_raddr  = cmd.bld_step ? sweep_r : rd_addr;

  assign fill_we    = cmd.clr_step || bv_r || fill_upd;
  assign fill_waddr = fill_upd ? id_r : (cmd.clr_step ? sweep_r : baddr_r);
  assign fill_wdata = fill_upd ? fill_rd + 1'b1 : '0;

  assign off_wdata  = sat_slot({1'b0, run_r});

  dbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DOMAINS)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  dbcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DOMAINS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (fill_rd)
  );

  dbcs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_DOMAINS)) u_offsets (
    .clk   (clk),
    .we    (bv_r),
    .waddr (baddr_r),
    .wdata (off_wdata),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (off_rd)
  );

  // x phase: sel / dx; y phase: (sel / dx) / dy
  assign div_start    = cmd.div_x || cmd.div_y;
  assign div_dividend = cmd.div_y ? div_quo : sel_r;
  assign div_divisor  = cmd.div_y ? dy : dx;

  dbcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    res_id     = '0;
    res_slot   = '0;
    res_count  = '0;
    res_status = STAT_OK;
    res_gx     = '0;
    res_gy     = '0;
    res_gz     = '0;
    case (cmd_r)
      OP_CLEAR: begin
        res_status = STAT_OK;
      end
      OP_COUNT: begin
        if (!id_ok_r) begin
          res_status = STAT_RANGE;
        end else begin
          res_id = ID_W'(id_r);
          res_gx = gx_r;
          res_gy = gy_r;
          res_gz = gz_r;
          if (full) begin
            res_count  = cnt_rd;
            res_status = STAT_FULL;
          end else begin
            res_count = cnt_rd + 1'b1;
          end
        end
      end
      OP_BUILD: begin
        res_count = total_r;
      end
      OP_PLACE: begin
        if (!id_ok_r) begin
          res_status = STAT_RANGE;
        end else begin
          res_id    = ID_W'(id_r);
          res_count = cnt_rd;
          res_gx    = gx_r;
          res_gy    = gy_r;
          res_gz    = gz_r;
          if (place_ok) begin
            res_slot = sat_slot(slot_sum);
          end else begin
            res_status = STAT_OVERFILL;
          end
        end
      end
      OP_READ: begin
        res_id = ID_W'(sel_r);
        if (!sel_ok) begin
          res_status = STAT_RANGE;
        end else begin
          res_slot  = off_rd;
          res_count = cnt_rd;
          res_gx    = gx_r;
          res_gy    = div_rem[G_W-1:0];
          res_gz    = div_quo[G_W-1:0];
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_id_r     <= res_id;
      out_slot_r   <= res_slot;
      out_count_r  <= res_count;
      out_status_r <= res_status;
      out_gx_r     <= res_gx;
      out_gy_r     <= res_gy;
      out_gz_r     <= res_gz;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.sel_ok     = sel_ok;
  assign stat.sweep_last = sweep_last;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_domain_id = out_id_r;
  assign out_slot      = out_slot_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;
  assign out_grid_x    = out_gx_r;
  assign out_grid_y    = out_gy_r;
  assign out_grid_z    = out_gz_r;

endmodule

`default_nettype wire

### sv/domain_binning_counting_sort.sv
// Top level of the domain binning counting sorter: config registers, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Bins atoms into a grid of up to 16x16x16 domains and sorts them by counting.
// One item is worked on at a time. Count and place step through decode, bin, index,
// read and finish for each accepted item, with one read-modify-write on the count and
// fill memories. Read domain gets its grid coordinates from a divider that makes one
// quotient bit per cycle, run twice. Clear and build offsets each walk all 4096 domains,
// one per cycle. After reset, a clearing pass over all 4096 domains zeroes counts and
// fill while in_stall stays high; register writes are taken during it. A result waits
// in an output register, so the next item may be accepted while it is stalled.

module domain_binning_counting_sort import dbcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [CMD_W-1:0]   in_command,
  input  wire logic [FRAC_W-1:0]  in_frac_x,
  input  wire logic [FRAC_W-1:0]  in_frac_y,
  input  wire logic [FRAC_W-1:0]  in_frac_z,
  input  wire logic [SEL_W-1:0]   in_domain_select,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [ID_W-1:0]    out_domain_id,
  output      logic [SLOT_W-1:0]  out_slot,
  output      logic [CNT_W-1:0]   out_count,
  output      logic [STAT_W-1:0]  out_status,
  output      logic [G_W-1:0]     out_grid_x,
  output      logic [G_W-1:0]     out_grid_y,
  output      logic [G_W-1:0]     out_grid_z,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  logic [DOM_W-1:0]  dom_x_r, dom_y_r, dom_z_r;
  logic [DOM_W-1:0]  dom_x_nxt, dom_y_nxt, dom_z_nxt;
  logic [RIDX_W-1:0] reg_idx;
  logic              wr_en;
  dbcs_cmd_t         cmd;
  dbcs_stat_t        stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    dom_x_nxt = dom_x_r;
    dom_y_nxt = dom_y_r;
    dom_z_nxt = dom_z_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DX:  dom_x_nxt = pwdata[DOM_W-1:0];
        REG_DY:  dom_y_nxt = pwdata[DOM_W-1:0];
        REG_DZ:  dom_z_nxt = pwdata[DOM_W-1:0];
        default: dom_x_nxt = dom_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dom_x_r <= DOM_W'(1);
      dom_y_r <= DOM_W'(1);
      dom_z_r <= DOM_W'(1);
    end else begin
      dom_x_r <= dom_x_nxt;
      dom_y_r <= dom_y_nxt;
      dom_z_r <= dom_z_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DX:  prdata = PDATA_W'(dom_x_r);
      REG_DY:  prdata = PDATA_W'(dom_y_r);
      REG_DZ:  prdata = PDATA_W'(dom_z_r);
      default: prdata = '0;
    endcase
  end

  dbcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dbcs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (in_command),
    .in_frac_x        (in_frac_x),
    .in_frac_y        (in_frac_y),
    .in_frac_z        (in_frac_z),
    .in_domain_select (in_domain_select),
    .dom_x            (dom_x_r),
    .dom_y            (dom_y_r),
    .dom_z            (dom_z_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_domain_id    (out_domain_id),
    .out_slot         (out_slot),
    .out_count        (out_count),
    .out_status       (out_status),
    .out_grid_x       (out_grid_x),
    .out_grid_y       (out_grid_y),
    .out_grid_z       (out_grid_z)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in work");

  a_init_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("item accepted before the clearing pass");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_RANGE)) |->
      (out_slot == '0 && out_count == '0 && out_grid_x == '0 &&
       out_grid_y == '0 && out_grid_z == '0))
    else $error("range error item carries data");

  a_overfill_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_OVERFILL)) |-> (out_slot == '0))
    else $error("overfilled domain returned a slot");
`endif

endmodule

`default_nettype wire
